@@ sv/rn_pkg.sv @@
package rn_pkg;

    // Default fraction width
    localparam int DEF_WIDTH = 32;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_ZERO_DEN = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;

endpackage

@@ sv/rational_normalizer.sv @@
// Fraction reducer: takes numerator/denominator words and returns the
// fraction in lowest terms with the sign on the numerator.
// Input channel (i_s_*): one word carries numer_in and denom_in; accepted
// when i_s_tvalid and o_s_tready are both high. o_s_tready is high while
// the sequencer is idle, so one fraction is in work at a time.
// Output channel (o_m_*): numer_out and denom_out in tdata, is_integer and
// status in tuser; held in an output register until i_m_tready.
// Sequencing: a zero numerator or denominator goes straight to the final
// state. Otherwise common factors of two are stripped first, the binary
// gcd loop follows (one subtract-and-shift per cycle), then the numerator
// and the denominator are divided by the gcd in turn on one restoring divider.
// A stalled receiver does not stop the next fraction from being taken
// and worked on; only the final load into the output register waits.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_m_tvalid; no result in flight survives it.
module rational_normalizer import rn_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: numer_in, denom_in
    input  logic [((2*WIDTH+7)/8)*8-1:0]         i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata: numer_out, denom_out
    output logic [((2*WIDTH+7)/8)*8-1:0]         o_m_tdata,
    // tuser: is_integer, status
    output logic [7:0]                           o_m_tuser
);

    localparam int TW = ((2*WIDTH+7)/8)*8;
    localparam int KW = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE, S_TWOS, S_GCD, S_DIVN, S_DIVD, S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic             r_neg, n_neg;
    logic [WIDTH-1:0] r_an, n_an;
    logic [WIDTH-1:0] r_ad, n_ad;
    logic [WIDTH-1:0] r_u, n_u;
    logic [WIDTH-1:0] r_v, n_v;
    logic [KW-1:0]    r_k, n_k;
    logic [WIDTH-1:0] r_g, n_g;
    logic [WIDTH-1:0] r_qn, n_qn;
    logic [WIDTH-1:0] r_res_n, n_res_n;
    logic [WIDTH-1:0] r_res_d, n_res_d;
    logic             r_res_i, n_res_i;
    t_status          r_res_s, n_res_s;
    logic             r_ov, n_ov;
    logic [WIDTH-1:0] r_on, n_on;
    logic [WIDTH-1:0] r_od, n_od;
    logic             r_oi, n_oi;
    t_status          r_os, n_os;

    logic [WIDTH-1:0] in_num, in_den;
    logic [WIDTH:0]   umv;
    logic [WIDTH-1:0] vmu;
    logic [WIDTH-1:0] gcd_val;
    logic             div_start;
    logic [WIDTH-1:0] div_a, div_b;
    logic             div_done;
    logic [WIDTH-1:0] div_q;

    assign in_num = i_s_tdata[WIDTH-1:0];
    assign in_den = i_s_tdata[2*WIDTH-1:WIDTH];

    // Shared divider for both reductions by the gcd
    rn_divider #(.WIDTH(WIDTH)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Sequencer and datapath next state
    always_comb begin
        umv     = {1'b0, r_u} - {1'b0, r_v};
        vmu     = r_v - r_u;
        gcd_val = r_v << r_k;

        n_state = r_state;
        n_neg   = r_neg;
        n_an    = r_an;
        n_ad    = r_ad;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        n_g     = r_g;
        n_qn    = r_qn;
        n_res_n = r_res_n;
        n_res_d = r_res_d;
        n_res_i = r_res_i;
        n_res_s = r_res_s;
        n_ov    = r_ov;
        n_on    = r_on;
        n_od    = r_od;
        n_oi    = r_oi;
        n_os    = r_os;

        div_start = 1'b0;
        div_a     = r_an;
        div_b     = gcd_val;

        // output word taken
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_neg = in_num[WIDTH-1] ^ in_den[WIDTH-1];
                    n_an  = in_num[WIDTH-1] ? (WIDTH'(0) - in_num) : in_num;
                    n_ad  = in_den[WIDTH-1] ? (WIDTH'(0) - in_den) : in_den;
                    n_u   = in_num[WIDTH-1] ? (WIDTH'(0) - in_num) : in_num;
                    n_v   = in_den[WIDTH-1] ? (WIDTH'(0) - in_den) : in_den;
                    n_k   = '0;
                    n_res_n = '0;
                    n_res_d = WIDTH'(1);
                    if (in_den == '0) begin
                        // zero denominator: error result
                        n_res_i = 1'b0;
                        n_res_s = ST_ZERO_DEN;
                        n_state = S_FIN;
                    end else if (in_num == '0) begin
                        // zero numerator reduces to 0/1
                        n_res_i = 1'b1;
                        n_res_s = ST_OK;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_TWOS;
                    end
                end
            end
            S_TWOS: begin
                // strip common factors of two, then keep v odd
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + KW'(1);
                end else begin
                    if (!r_v[0]) begin
                        n_u = r_v;
                        n_v = r_u;
                    end
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                // binary gcd step, v stays odd
                if (r_u == '0) begin
                    div_start = 1'b1;
                    n_g       = gcd_val;
                    n_state   = S_DIVN;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!umv[WIDTH]) begin
                    n_u = {1'b0, umv[WIDTH-1:1]};
                end else begin
                    n_u = {1'b0, vmu[WIDTH-1:1]};
                    n_v = r_u;
                end
            end
            S_DIVN: begin
                div_a = r_ad;
                div_b = r_g;
                if (div_done) begin
                    n_qn      = div_q;
                    div_start = 1'b1;
                    n_state   = S_DIVD;
                end
            end
            S_DIVD: begin
                if (div_done) begin
                    n_res_d = div_q;
                    n_res_i = (div_q == WIDTH'(1));
                    n_res_s = ST_OK;
                    if (r_neg) begin
                        n_res_n = WIDTH'(0) - r_qn;
                    end else if (r_qn[WIDTH-1]) begin
                        // magnitude 2^(WIDTH-1) does not fit positive
                        n_res_n = {1'b0, {(WIDTH-1){1'b1}}};
                        n_res_s = ST_OVERFLOW;
                    end else begin
                        n_res_n = r_qn;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // load the output register once it is free
                if (!r_ov || i_m_tready) begin
                    n_ov    = 1'b1;
                    n_on    = r_res_n;
                    n_od    = r_res_d;
                    n_oi    = r_res_i;
                    n_os    = r_res_s;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
        r_neg   <= n_neg;
        r_an    <= n_an;
        r_ad    <= n_ad;
        r_u     <= n_u;
        r_v     <= n_v;
        r_k     <= n_k;
        r_g     <= n_g;
        r_qn    <= n_qn;
        r_res_n <= n_res_n;
        r_res_d <= n_res_d;
        r_res_i <= n_res_i;
        r_res_s <= n_res_s;
        r_on    <= n_on;
        r_od    <= n_od;
        r_oi    <= n_oi;
        r_os    <= n_os;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = TW'({r_od, r_on});
    assign o_m_tuser  = {5'b0, r_os, r_oi};

endmodule

@@ sv/rn_divider.sv @@
module rn_divider import rn_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_div, n_div;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // Restoring divide: one quotient bit per cycle, MSB first
    always_comb begin
        rem_sh = {r_rem, r_quo[WIDTH-1]};
        diff   = rem_sh - {1'b0, r_div};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
            n_cnt  = CW'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
